// ===== design/trsx_pkg.sv =====
package trsx_pkg;

    localparam int XLEN      = 32;
    localparam int MEM_WORDS = 256;
    localparam int NUM_REGS  = 32;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_IW    = 5;

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [REG_IW-1:0] t_reg_idx;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_ADDI = 3'd2,
        OP_LW   = 3'd3,
        OP_SW   = 3'd4,
        OP_BEQ  = 3'd5,
        OP_BNE  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_OP   = 2'd1,
        ERR_ADDR = 2'd2
    } t_err;

    typedef struct packed {
        logic     en;
        t_reg_idx idx;
        t_word    data;
    } t_rf_wr;

endpackage

// ===== design/trsx_channels.sv =====
interface trsx_in_if;
    import trsx_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;

    modport source (
        output valid, operation, dest_reg, src_reg_a, src_reg_b, immediate,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_reg, src_reg_a, src_reg_b, immediate,
        output ready
    );
endinterface

interface trsx_out_if;
    import trsx_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] next_pc;
    logic               reg_written;
    logic [4:0]         written_index;
    logic signed [31:0] written_value;
    logic [1:0]         error_code;

    modport source (
        output valid, next_pc, reg_written, written_index, written_value, error_code,
        input  ready
    );
    modport sink (
        input  valid, next_pc, reg_written, written_index, written_value, error_code,
        output ready
    );
endinterface

// ===== design/trsx_regfile.sv =====
module trsx_regfile
    import trsx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_rd_en,
    input  t_reg_idx i_ra_idx,
    input  t_reg_idx i_rb_idx,
    input  t_rf_wr   i_wr,
    output t_word    o_a,
    output t_word    o_b
);

    t_word               r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    t_word               r_a;
    t_word               r_b;
    t_word               n_a;
    t_word               n_b;

    // read sees the write landing on the same edge
    function automatic t_word rd_port(t_reg_idx idx, t_rf_wr wr, t_word data,
                                      logic vld);
        t_word res;
        res = '0;
        if (wr.en && wr.idx == idx) begin
            res = wr.data;
        end else if (int'(idx) < NUM_REGS && vld) begin
            res = data;
        end
        return res;
    endfunction

    always_comb begin
        n_a = rd_port(i_ra_idx, i_wr, r_mem[i_ra_idx[RF_AW-1:0]],
                      r_vld[i_ra_idx[RF_AW-1:0]]);
        n_b = rd_port(i_rb_idx, i_wr, r_mem[i_rb_idx[RF_AW-1:0]],
                      r_vld[i_rb_idx[RF_AW-1:0]]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx[RF_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx[RF_AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

// ===== design/tiny_riscv_subset_execute_core.sv =====
// Execute core for a small RV32I-style subset: ADD, SUB, ADDI, LW, SW, BEQ, BNE.
// One decoded instruction per item, one result per item. Throughput is one item
// per clock while results are taken, with no hazard stalls. Each item is registered
// in stage 1, then stage 2. Stage 1 reads the register file (registered read) and
// executes: ALU, address check, branch and program counter update, store, and the
// data memory read. Stage 2 holds the result and writes the register file when the
// result is taken; its value is forwarded to the item in stage 1. x0 reads zero.
// Register file and data memory read as zero after reset, no clearing time.
// Unknown operations and out-of-range addresses report an error and change nothing.
module tiny_riscv_subset_execute_core
    import trsx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    trsx_in_if.sink    i_in,
    trsx_out_if.source o_out
);

    logic en1;
    logic en2;
    logic s1_move;

    logic     r_s1_vld;
    logic [2:0] r_s1_op;
    t_reg_idx r_s1_rd;
    t_reg_idx r_s1_ra;
    t_reg_idx r_s1_rb;
    t_word    r_s1_imm;

    logic     r_s2_vld;
    t_word    r_s2_pc;
    logic     r_s2_wr;
    t_reg_idx r_s2_rd;
    logic     r_s2_load;
    t_word    r_s2_alu;
    t_err     r_s2_err;

    t_word    r_pc;

    t_word                r_dmem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_dmem_vld;
    t_word                r_mem_rdata;
    logic                 r_mem_rvld;

    t_word  rf_a;
    t_word  rf_b;
    t_rf_wr rf_wr;
    t_word  s2_wval;

    t_word  s1_a;
    t_word  s1_b;
    t_word  s1_addr;
    logic   s1_addr_ok;
    logic [MEM_AW-1:0] s1_midx;
    t_word  s1_alu;
    logic   s1_wr_raw;
    logic   s1_wr;
    logic   s1_load;
    logic   s1_store;
    logic   s1_take;
    t_err   s1_err;
    t_word  n_pc;

    assign en2     = !r_s2_vld || o_out.ready;
    assign en1     = !r_s1_vld || en2;
    assign s1_move = r_s1_vld && en2;
    assign i_in.ready = en1;

    assign s2_wval = r_s2_load ? (r_mem_rvld ? r_mem_rdata : '0) : r_s2_alu;

    always_comb begin
        rf_wr.en   = r_s2_vld && r_s2_wr && o_out.ready;
        rf_wr.idx  = r_s2_rd;
        rf_wr.data = s2_wval;
    end

    trsx_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (en1),
        .i_ra_idx (i_in.src_reg_a),
        .i_rb_idx (i_in.src_reg_b),
        .i_wr     (rf_wr),
        .o_a      (rf_a),
        .o_b      (rf_b)
    );

    // forward from the older item still waiting in stage 2
    always_comb begin
        s1_a = (r_s2_vld && r_s2_wr && r_s2_rd == r_s1_ra) ? s2_wval : rf_a;
        s1_b = (r_s2_vld && r_s2_wr && r_s2_rd == r_s1_rb) ? s2_wval : rf_b;
    end

    always_comb begin
        s1_addr    = s1_a + r_s1_imm;
        s1_addr_ok = s1_addr < t_word'(MEM_WORDS);
        s1_midx    = s1_addr[MEM_AW-1:0];
        s1_alu     = '0;
        s1_wr_raw  = 1'b0;
        s1_load    = 1'b0;
        s1_store   = 1'b0;
        s1_take    = 1'b0;
        s1_err     = ERR_OK;
        unique case (t_op'(r_s1_op))
            OP_ADD: begin
                s1_wr_raw = 1'b1;
                s1_alu    = s1_a + s1_b;
            end
            OP_SUB: begin
                s1_wr_raw = 1'b1;
                s1_alu    = s1_a - s1_b;
            end
            OP_ADDI: begin
                s1_wr_raw = 1'b1;
                s1_alu    = s1_addr;
            end
            OP_LW: begin
                if (s1_addr_ok) begin
                    s1_wr_raw = 1'b1;
                    s1_load   = 1'b1;
                end else begin
                    s1_err = ERR_ADDR;
                end
            end
            OP_SW: begin
                if (s1_addr_ok) begin
                    s1_store = 1'b1;
                end else begin
                    s1_err = ERR_ADDR;
                end
            end
            OP_BEQ: begin
                s1_take = (s1_a == s1_b);
            end
            OP_BNE: begin
                s1_take = (s1_a != s1_b);
            end
            default: begin
                s1_err = ERR_OP;
            end
        endcase
        s1_wr = s1_wr_raw && r_s1_rd != '0 && int'(r_s1_rd) < NUM_REGS;
        if (s1_err != ERR_OK) begin
            n_pc = r_pc;
        end else if (s1_take && r_s1_imm != r_pc) begin
            n_pc = r_s1_imm;
        end else begin
            n_pc = r_pc + t_word'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_pc       <= '0;
            r_dmem_vld <= '0;
        end else begin
            if (en1) begin
                r_s1_vld <= i_in.valid;
            end
            if (en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s1_move) begin
                r_pc <= n_pc;
                if (s1_store) begin
                    r_dmem_vld[s1_midx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op  <= i_in.operation;
            r_s1_rd  <= i_in.dest_reg;
            r_s1_ra  <= i_in.src_reg_a;
            r_s1_rb  <= i_in.src_reg_b;
            r_s1_imm <= t_word'(i_in.immediate);
        end
        if (s1_move) begin
            r_s2_pc   <= n_pc;
            r_s2_wr   <= s1_wr;
            r_s2_rd   <= r_s1_rd;
            r_s2_load <= s1_load;
            r_s2_alu  <= s1_alu;
            r_s2_err  <= s1_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && s1_store) begin
            r_dmem[s1_midx] <= s1_b;
        end
        if (s1_move) begin
            r_mem_rdata <= r_dmem[s1_midx];
            r_mem_rvld  <= r_dmem_vld[s1_midx];
        end
    end

    always_comb begin
        o_out.valid         = r_s2_vld;
        o_out.next_pc       = r_s2_pc;
        o_out.reg_written   = r_s2_wr;
        o_out.written_index = r_s2_wr ? r_s2_rd : '0;
        o_out.written_value = r_s2_wr ? s2_wval : '0;
        o_out.error_code    = r_s2_err;
    end

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_wr |-> r_s2_rd != '0)
        else $error("write to x0 reported");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_err != ERR_OK |-> !r_s2_wr)
        else $error("register write on error");

    a_err_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && s1_err != ERR_OK |=> r_pc == $past(r_pc))
        else $error("program counter moved on error");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && s1_err == ERR_OK && !s1_take |=> r_pc == $past(r_pc) + t_word'(1))
        else $error("program counter did not advance");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s2_vld && !o_out.ready |=> r_s1_vld && $stable(r_s1_op))
        else $error("stage 1 item lost under stall");

endmodule

// ===== test/tb_tiny_riscv_subset_execute_core.sv =====
module tb_tiny_riscv_subset_execute_core;
    timeunit 1ns;
    timeprecision 1ps;

    import trsx_pkg::*;

    localparam int N_RANDOM     = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 100;

    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        t_reg_idx   rd;
        t_reg_idx   ra;
        t_reg_idx   rb;
        t_word      imm;
    } t_instr;

    typedef struct packed {
        t_word    next_pc;
        logic     wr;
        t_reg_idx idx;
        t_word    val;
        t_err     err;
    } t_retire;

    typedef struct {
        t_instr  ins;
        bit      has_lit;
        t_retire lit;
    } t_dir_row;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    trsx_in_if  in_ch();
    trsx_out_if out_ch();

    tiny_riscv_subset_execute_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_word    arch_regs [NUM_REGS];
    t_word    arch_mem  [MEM_WORDS];
    t_word    arch_pc;
    t_retire  retire_q [$];
    t_dir_row dir_rows [$];
    int       mismatches = 0;
    int       cycles;
    int       burst_left;
    t_rx_mode rx_mode;
    int       rx_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_word read_arch_reg(t_reg_idx idx);
        if (idx == '0 || idx >= NUM_REGS) begin
            return '0;
        end
        return arch_regs[idx];
    endfunction

    // Retires one instruction against the architectural copy and returns its result.
    function automatic t_retire execute_instr(t_instr ins);
        t_word   a;
        t_word   b;
        t_word   addr;
        t_word   wval;
        t_word   new_pc;
        logic    wr;
        t_err    err;
        t_retire res;
        a      = read_arch_reg(ins.ra);
        b      = read_arch_reg(ins.rb);
        addr   = a + ins.imm;
        new_pc = arch_pc;
        wr     = 1'b0;
        wval   = '0;
        err    = ERR_OK;
        case (ins.op)
            OP_ADD: begin
                wr   = 1'b1;
                wval = a + b;
            end
            OP_SUB: begin
                wr   = 1'b1;
                wval = a - b;
            end
            OP_ADDI: begin
                wr   = 1'b1;
                wval = a + ins.imm;
            end
            OP_LW: begin
                if (addr < MEM_WORDS) begin
                    wr   = 1'b1;
                    wval = arch_mem[addr[MEM_AW-1:0]];
                end else begin
                    err = ERR_ADDR;
                end
            end
            OP_SW: begin
                if (addr < MEM_WORDS) begin
                    arch_mem[addr[MEM_AW-1:0]] = b;
                end else begin
                    err = ERR_ADDR;
                end
            end
            OP_BEQ: begin
                if (a == b) new_pc = ins.imm;
            end
            OP_BNE: begin
                if (a != b) new_pc = ins.imm;
            end
            default: begin
                err = ERR_OP;
            end
        endcase
        if (wr && (ins.rd == '0 || ins.rd >= NUM_REGS)) wr = 1'b0;
        if (wr) arch_regs[ins.rd] = wval;
        if (err == ERR_OK) begin
            if (new_pc == arch_pc) new_pc = arch_pc + 1;
            arch_pc = new_pc;
        end
        res.next_pc = arch_pc;
        res.wr      = wr;
        res.idx     = wr ? ins.rd : '0;
        res.val     = wr ? wval : '0;
        res.err     = err;
        return res;
    endfunction

    function automatic t_instr gen_instr();
        t_instr ins;
        int     sel;
        t_word  target;
        sel = $urandom_range(0, 99);
        if (sel < 12) ins.op = OP_ADD;
        else if (sel < 24) ins.op = OP_SUB;
        else if (sel < 42) ins.op = OP_ADDI;
        else if (sel < 58) ins.op = OP_LW;
        else if (sel < 74) ins.op = OP_SW;
        else if (sel < 84) ins.op = OP_BEQ;
        else if (sel < 94) ins.op = OP_BNE;
        else ins.op = OP_UNKNOWN;
        ins.rd  = t_reg_idx'($urandom_range(0, 31));
        ins.ra  = t_reg_idx'($urandom_range(0, 31));
        ins.rb  = t_reg_idx'($urandom_range(0, 31));
        ins.imm = $urandom();
        // crowd onto a few registers so back-to-back dependences are common
        if ($urandom_range(0, 2) == 0) begin
            ins.rd = t_reg_idx'($urandom_range(0, 3));
            ins.ra = t_reg_idx'($urandom_range(0, 3));
            ins.rb = t_reg_idx'($urandom_range(0, 3));
        end
        case (ins.op)
            OP_ADD, OP_SUB, OP_ADDI: begin
                case ($urandom_range(0, 9))
                    0: ins.imm = 32'h7FFF_FFFF;
                    1: ins.imm = 32'h8000_0000;
                    2: ins.imm = 32'hFFFF_FFFF;
                    3, 4, 5: ins.imm = t_word'(int'($urandom_range(0, 64)) - 32);
                    default: ;
                endcase
            end
            OP_LW, OP_SW: begin
                sel = $urandom_range(0, 19);
                if (sel < 10) target = $urandom_range(0, 15);
                else if (sel < 16) target = $urandom_range(0, MEM_WORDS - 1);
                else if (sel == 16) target = MEM_WORDS;
                else if (sel == 17) target = 32'hFFFF_FFFF;
                else target = $urandom();
                ins.imm = target - read_arch_reg(ins.ra);
            end
            OP_BEQ, OP_BNE: begin
                if ($urandom_range(0, 2) == 0) ins.rb = ins.ra;
                sel = $urandom_range(0, 9);
                if (sel < 2) ins.imm = arch_pc;
                else if (sel < 6) ins.imm = arch_pc + t_word'(int'($urandom_range(0, 40)) - 20);
            end
            default: ;
        endcase
        return ins;
    endfunction

    function automatic void add_row(logic [2:0] op, int rd, int ra, int rb, t_word imm);
        t_dir_row r;
        r.ins     = '{op: op, rd: t_reg_idx'(rd), ra: t_reg_idx'(ra), rb: t_reg_idx'(rb),
                      imm: imm};
        r.has_lit = 1'b0;
        r.lit     = '0;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void add_row_lit(logic [2:0] op, int rd, int ra, int rb,
                                        t_word imm, t_word pc, logic wr,
                                        int idx, t_word val, t_err err);
        t_dir_row r;
        r.ins     = '{op: op, rd: t_reg_idx'(rd), ra: t_reg_idx'(ra), rb: t_reg_idx'(rb),
                      imm: imm};
        r.has_lit = 1'b1;
        r.lit     = '{next_pc: pc, wr: wr, idx: t_reg_idx'(idx), val: val, err: err};
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        end
    endtask

    task automatic check_retire();
        t_retire want;
        if (retire_q.size() == 0) begin
            report_mismatch("unexpected item, next_pc", out_ch.next_pc, '0);
            return;
        end
        want = retire_q.pop_front();
        if (out_ch.next_pc !== want.next_pc)
            report_mismatch("next_pc", out_ch.next_pc, want.next_pc);
        if (out_ch.reg_written !== want.wr)
            report_mismatch("reg_written", t_word'(out_ch.reg_written), t_word'(want.wr));
        if (out_ch.written_index !== want.idx)
            report_mismatch("written_index", t_word'(out_ch.written_index), t_word'(want.idx));
        if (out_ch.written_value !== want.val)
            report_mismatch("written_value", out_ch.written_value, want.val);
        if (out_ch.error_code !== want.err)
            report_mismatch("error_code", t_word'(out_ch.error_code), t_word'(want.err));
    endtask

    // Bursts of random length, separated by random idle gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic issue(t_instr ins, bit has_lit, t_retire lit);
        t_retire pred;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= ins.op;
        in_ch.dest_reg  <= ins.rd;
        in_ch.src_reg_a <= ins.ra;
        in_ch.src_reg_b <= ins.rb;
        in_ch.immediate <= ins.imm;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = execute_instr(ins);
        retire_q.insert(retire_q.size(), has_lit ? lit : pred);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_left = 0;
            rx_mode = RX_OPEN;
        end else begin
            if (out_ch.valid && out_ch.ready) check_retire();
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(40, 250);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:     out_ch.ready <= 1'b1;
                RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: out_ch.ready <= (rx_left % 5) != 0;
                default:     out_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** tiny_riscv_subset_execute_core: FAILED **");
        $finish;
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.operation = '0;
        in_ch.dest_reg  = '0;
        in_ch.src_reg_a = '0;
        in_ch.src_reg_b = '0;
        in_ch.immediate = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;
        arch_pc    = '0;
        burst_left = 0;

        add_row_lit(OP_UNKNOWN, 0, 0, 0, 32'h0, 32'd0, 1'b0, 0, 32'h0, ERR_OP);
        add_row_lit(OP_LW, 1, 0, 0, 32'h0, 32'd1, 1'b1, 1, 32'h0, ERR_OK);
        add_row_lit(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 32'd2, 1'b1, 1, 32'h7FFF_FFFF, ERR_OK);
        add_row_lit(OP_ADDI, 2, 0, 0, 32'h8000_0000, 32'd3, 1'b1, 2, 32'h8000_0000, ERR_OK);
        add_row(OP_ADD, 3, 1, 1, 32'h0);
        add_row(OP_SUB, 4, 2, 1, 32'h0);
        add_row(OP_ADDI, 0, 1, 0, 32'd5);
        add_row(OP_SW, 0, 0, 1, 32'd255);
        add_row(OP_LW, 5, 0, 0, 32'd255);
        add_row_lit(OP_LW, 6, 0, 0, 32'd256, 32'd8, 1'b0, 0, 32'h0, ERR_ADDR);
        add_row_lit(OP_SW, 0, 0, 1, 32'hFFFF_FFFF, 32'd8, 1'b0, 0, 32'h0, ERR_ADDR);
        add_row(OP_LW, 7, 2, 0, 32'h8000_0005);
        add_row(OP_SW, 0, 1, 3, 32'h8000_0001);
        add_row(OP_BEQ, 0, 1, 1, 32'd100);
        add_row(OP_BNE, 0, 1, 1, 32'd5);
        add_row(OP_BNE, 0, 1, 2, 32'd101);
        add_row(OP_BEQ, 0, 1, 2, 32'd0);
        add_row(OP_BEQ, 0, 0, 0, 32'h7FFF_FFFF);
        add_row(OP_ADD, 31, 1, 2, 32'h0);
        add_row(OP_BEQ, 0, 0, 0, 32'hFFFF_FFFF);
        add_row(OP_ADDI, 8, 31, 0, 32'd1);
        add_row_lit(OP_UNKNOWN, 31, 31, 31, 32'hFFFF_FFFF, 32'd0, 1'b0, 0, 32'h0, ERR_OP);
        add_row(OP_LW, 9, 0, 0, 32'h0);
        add_row(OP_SUB, 10, 0, 31, 32'h0);
        add_row(OP_ADD, 0, 31, 31, 32'h0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            pace_sender();
            issue(dir_rows[i].ins, dir_rows[i].has_lit, dir_rows[i].lit);
        end
        repeat (N_RANDOM) begin
            pace_sender();
            issue(gen_instr(), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (retire_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** tiny_riscv_subset_execute_core: PASSED **");
        end else begin
            $display("** tiny_riscv_subset_execute_core: FAILED **");
        end
        $finish;
    end

endmodule
